@@ rtl/bmpsteg_pkg.sv @@
// Shared types, codes and defaults for the BMP LSB stego address/bit engine.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package bmpsteg_pkg;

   // Geometry defaults
   localparam int MAX_DIM_DEF = 16384;
   localparam int DEF_DIM_W   = $clog2(MAX_DIM_DEF + 1);
   localparam int DEF_RBC_W   = DEF_DIM_W + 2;

   // Fixed field widths
   localparam int ADDR_W     = 30;
   localparam int CFG_DIM_W  = 15;
   localparam int CFG_BPP_W  = 3;
   localparam int CSR_DATA_W = 15;
   localparam int CSR_IDX_W  = 2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BYTES_PER_PIXEL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TOP_DOWN        = 2'd3;

   // Item modes
   localparam logic [1:0] MODE_RESTART = 2'd0;
   localparam logic [1:0] MODE_EMBED   = 2'd1;
   localparam logic [1:0] MODE_EXTRACT = 2'd2;

   // Pixel size codes
   localparam logic [CFG_BPP_W-1:0] BPP_32BIT = 3'd4;
   localparam logic [CFG_BPP_W-1:0] BPP_24BIT = 3'd3;

   // Last bit index of an embedded byte
   localparam logic [2:0] EMBED_LAST_BIT = 3'd7;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] payload_byte;
      logic [7:0] pixel_byte;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] pixel_address;
      logic              write_lsb;
      logic              lsb_value;
      logic              byte_ready;
      logic [7:0]        extracted_byte;
      logic              status;
      logic              last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CAP_MUL,
      ST_ROW_MUL,
      ST_EMBED,
      ST_EMIT
   } state_type;

endpackage

@@ rtl/bmpsteg_serial_mul.sv @@
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on bmpsteg_pkg for default widths.
`timescale 1ns / 1ps

module bmpsteg_serial_mul #(
   parameter int A_W = bmpsteg_pkg::DEF_DIM_W,
   parameter int B_W = bmpsteg_pkg::DEF_RBC_W
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [A_W-1:0]     mplier,
   input  logic [B_W-1:0]     mcand,
   output logic               done,
   output logic [A_W+B_W-1:0] product
);
   import bmpsteg_pkg::*;

   localparam int P_W   = A_W + B_W;
   localparam int CNT_W = $clog2(A_W + 1);

   logic               busy_ff, busy_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [B_W-1:0]     mcand_ff, mcand_in;
   logic [P_W-1:0]     prod_ff, prod_in;
   logic [B_W:0]       sum;
   logic [P_W:0]       shifted;

   // upper half accumulates, low half holds remaining multiplier bits
   assign sum     = {1'b0, prod_ff[P_W-1:A_W]} + (prod_ff[0] ? {1'b0, mcand_ff} : '0);
   assign shifted = {sum, prod_ff[A_W-1:0]};
   assign done    = busy_ff && (cnt_ff == '0);
   assign product = prod_ff;

   always_comb begin
      busy_in  = busy_ff;
      cnt_in   = cnt_ff;
      mcand_in = mcand_ff;
      prod_in  = prod_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = CNT_W'(A_W);
         mcand_in = mcand;
         prod_in  = {{B_W{1'b0}}, mplier};
      end else if (busy_ff) begin
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            cnt_in  = cnt_ff - CNT_W'(1);
            prod_in = shifted[P_W:1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      mcand_ff <= mcand_in;
      prod_ff  <= prod_in;
   end

endmodule

@@ rtl/bmp_lsb_stego_embed_extract_core.sv @@
// Top level of the BMP LSB stego address/bit engine: sequencer, walk state, result register.
// Depends on bmpsteg_pkg and bmpsteg_serial_mul.
`timescale 1ns / 1ps

// Usage
//  req channel (valid/ready): one word per item, mode restart / embed / extract.
//  rsp channel (valid/ready): result words, last marks the final word of an item.
//  csr port: write enable, index, data; write only while the block is idle.
//  Restart: one word after two serial multiplies (capacity = height*row_bytes/8,
//    then first row base = stored_row*stride).
//  Embed: eight words, one per cycle while the receiver keeps up and no row is crossed, MSB of the payload first.
//  Extract: one word.
//  Each step across a row boundary waits for the new row base, which comes from
//    the shared bit-serial multiplier (DIM_W = 15 at the default MAX_DIM).
//  Rejected items (capacity used up) give one word with status set.
//  One item is in work at a time; req_ready is high only while the sequencer is idle.
//  A one-word output register holds a result while the receiver stalls; the
//    sequencer waits for it to empty and nothing is dropped.
//  Reset (synchronous): geometry 24-bit, 1x1, bottom-up; capacity zero, so embed and
//    extract are rejected until a restart item.
module bmp_lsb_stego_embed_extract_core #(
   parameter int MAX_DIM = bmpsteg_pkg::MAX_DIM_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  bmpsteg_pkg::req_type                 req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output bmpsteg_pkg::rsp_type                 rsp_data,
   input  logic                                 csr_write_enable,
   input  logic [bmpsteg_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bmpsteg_pkg::CSR_DATA_W-1:0]   csr_write_data
);
   import bmpsteg_pkg::*;

   localparam int DIM_W = $clog2(MAX_DIM + 1);
   localparam int ROW_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int RBC_W = DIM_W + 2;        // row bytes / stride
   localparam int COL_W = RBC_W - 1;        // byte within a row
   localparam int P_W   = DIM_W + RBC_W;    // multiplier product
   localparam int CAP_W = P_W - 3;          // capacity in bytes

   // ---------------- configuration registers ----------------
   logic [CFG_BPP_W-1:0] bpp_ff;
   logic [CFG_DIM_W-1:0] width_ff;
   logic [CFG_DIM_W-1:0] height_ff;
   logic                 top_down_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff      <= BPP_24BIT;
         width_ff    <= CFG_DIM_W'(1);
         height_ff   <= CFG_DIM_W'(1);
         top_down_ff <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_BYTES_PER_PIXEL: bpp_ff      <= csr_write_data[CFG_BPP_W-1:0];
            CSR_IMAGE_WIDTH:     width_ff    <= csr_write_data[CFG_DIM_W-1:0];
            CSR_IMAGE_HEIGHT:    height_ff   <= csr_write_data[CFG_DIM_W-1:0];
            CSR_TOP_DOWN:        top_down_ff <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // zero reads as one, large values clamp to MAX_DIM
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DIM_W-1:0] v);
      if (v == '0) begin
         return DIM_W'(1);
      end else if (32'(v) > MAX_DIM) begin
         return DIM_W'(MAX_DIM);
      end else begin
         return DIM_W'(v);
      end
   endfunction

   logic [DIM_W-1:0] w_cfg, h_cfg;
   logic [RBC_W-1:0] rbc_cfg, stride_cfg;
   logic [RBC_W:0]   rbc_p3;

   assign w_cfg = clamp_dim(width_ff);
   assign h_cfg = clamp_dim(height_ff);
   // any pixel size other than 32-bit is taken as 24-bit
   assign rbc_cfg = (bpp_ff == BPP_32BIT) ? (RBC_W'(w_cfg) << 2)
                                         : (RBC_W'(w_cfg) + (RBC_W'(w_cfg) << 1));
   assign rbc_p3     = {1'b0, rbc_cfg} + (RBC_W+1)'(3);
   assign stride_cfg = {rbc_p3[RBC_W-1:2], 2'b00};

   // ---------------- walk state ----------------
   state_type         state_ff, state_in;
   logic [1:0]        mode_ff, mode_in;
   logic [7:0]        payload_ff, payload_in;
   logic [2:0]        cnt_ff, cnt_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ADDR_W-1:0] base_ff, base_in;
   logic [RBC_W-1:0]  rbc_ff, rbc_in;
   logic [RBC_W-1:0]  stride_ff, stride_in;
   logic [2:0]        bitpos_ff, bitpos_in;
   logic [7:0]        gather_ff, gather_in;
   logic [CAP_W-1:0]  done_bytes_ff, done_bytes_in;
   logic [CAP_W-1:0]  capacity_ff, capacity_in;
   logic              emit_status_ff, emit_status_in;
   logic              emit_ready_ff, emit_ready_in;
   logic [7:0]        emit_byte_ff, emit_byte_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              accept, out_free, rejected;
   logic              mul_start, mul_done;
   logic [DIM_W-1:0]  mul_a;
   logic [RBC_W-1:0]  mul_b;
   logic [P_W-1:0]    mul_p;

   logic [RBC_W-1:0]  col_inc;
   logic              adv_wrap;
   logic [ROW_W:0]    row_inc;
   logic [ROW_W-1:0]  row_adv;
   logic [DIM_W-1:0]  stored_row_adv, stored_row_first;
   logic [ADDR_W-1:0] cur_addr;
   logic [7:0]        gather_next;
   logic [2:0]        bitpos_next;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rejected  = (done_bytes_ff >= capacity_ff);

   // next position in the walk
   assign col_inc  = {1'b0, col_ff} + RBC_W'(1);
   assign adv_wrap = (col_inc >= rbc_ff);
   assign row_inc  = {1'b0, row_ff} + (ROW_W+1)'(1);
   assign row_adv  = ((DIM_W+1)'(row_inc) >= {1'b0, h_cfg}) ? '0 : row_inc[ROW_W-1:0];
   assign stored_row_adv   = top_down_ff ? DIM_W'(row_adv)
                                         : (h_cfg - DIM_W'(1) - DIM_W'(row_adv));
   assign stored_row_first = top_down_ff ? '0 : (h_cfg - DIM_W'(1));
   assign cur_addr = ADDR_W'(base_ff + ADDR_W'(col_ff));

   assign gather_next = {gather_ff[6:0], req_data.pixel_byte[0]};
   assign bitpos_next = bitpos_ff + 3'd1;

   bmpsteg_serial_mul #(
      .A_W(DIM_W),
      .B_W(RBC_W)
   ) u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .mplier (mul_a),
      .mcand  (mul_b),
      .done   (mul_done),
      .product(mul_p)
   );

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_data.mode)
                  MODE_RESTART: state_in = ST_CAP_MUL;
                  MODE_EMBED:   state_in = rejected ? ST_EMIT : ST_EMBED;
                  MODE_EXTRACT: state_in = (!rejected && adv_wrap) ? ST_ROW_MUL : ST_EMIT;
                  default:      state_in = ST_IDLE;
               endcase
            end
         end
         ST_CAP_MUL: begin
            if (mul_done) state_in = ST_ROW_MUL;
         end
         ST_ROW_MUL: begin
            if (mul_done) begin
               if (mode_ff == MODE_EMBED) begin
                  // counter back at zero: all eight bits already sent
                  state_in = (cnt_ff == '0) ? ST_IDLE : ST_EMBED;
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMBED: begin
            if (out_free) begin
               if (adv_wrap)                       state_in = ST_ROW_MUL;
               else if (cnt_ff == EMBED_LAST_BIT)  state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------- datapath / outputs ----------------
   always_comb begin
      logic do_advance;
      do_advance     = 1'b0;
      mode_in        = mode_ff;
      payload_in     = payload_ff;
      cnt_in         = cnt_ff;
      row_in         = row_ff;
      col_in         = col_ff;
      base_in        = base_ff;
      rbc_in         = rbc_ff;
      stride_in      = stride_ff;
      bitpos_in      = bitpos_ff;
      gather_in      = gather_ff;
      done_bytes_in  = done_bytes_ff;
      capacity_in    = capacity_ff;
      emit_status_in = emit_status_ff;
      emit_ready_in  = emit_ready_ff;
      emit_byte_in   = emit_byte_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_in         = rsp_ff;
      mul_start      = 1'b0;
      mul_a          = stored_row_adv;
      mul_b          = stride_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               mode_in        = req_data.mode;
               payload_in     = req_data.payload_byte;
               emit_status_in = 1'b0;
               emit_ready_in  = 1'b0;
               emit_byte_in   = '0;
               case (req_data.mode)
                  MODE_RESTART: begin
                     rbc_in    = rbc_cfg;
                     stride_in = stride_cfg;
                     mul_start = 1'b1;
                     mul_a     = h_cfg;
                     mul_b     = rbc_cfg;
                  end
                  MODE_EMBED: begin
                     if (rejected) begin
                        emit_status_in = 1'b1;
                     end else begin
                        bitpos_in = '0;
                        gather_in = '0;
                        cnt_in    = '0;
                     end
                  end
                  MODE_EXTRACT: begin
                     if (rejected) begin
                        emit_status_in = 1'b1;
                     end else begin
                        do_advance = 1'b1;
                        bitpos_in  = bitpos_next;
                        if (bitpos_next == '0) begin
                           emit_ready_in = 1'b1;
                           emit_byte_in  = gather_next;
                           gather_in     = '0;
                           done_bytes_in = done_bytes_ff + CAP_W'(1);
                        end else begin
                           gather_in = gather_next;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_CAP_MUL: begin
            if (mul_done) begin
               capacity_in   = CAP_W'(mul_p >> 3);
               row_in        = '0;
               col_in        = '0;
               bitpos_in     = '0;
               gather_in     = '0;
               done_bytes_in = '0;
               mul_start     = 1'b1;
               mul_a         = stored_row_first;
               mul_b         = stride_ff;
            end
         end
         ST_ROW_MUL: begin
            if (mul_done) base_in = ADDR_W'(mul_p);
         end
         ST_EMBED: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_in.pixel_address  = cur_addr;
               rsp_in.write_lsb      = 1'b1;
               rsp_in.lsb_value      = payload_ff[7];
               rsp_in.byte_ready     = 1'b0;
               rsp_in.extracted_byte = '0;
               rsp_in.status         = 1'b0;
               rsp_in.last           = (cnt_ff == EMBED_LAST_BIT);
               payload_in            = {payload_ff[6:0], 1'b0};
               cnt_in                = cnt_ff + 3'd1;
               if (cnt_ff == EMBED_LAST_BIT) done_bytes_in = done_bytes_ff + CAP_W'(1);
               do_advance            = 1'b1;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_in.pixel_address  = cur_addr;
               rsp_in.write_lsb      = 1'b0;
               rsp_in.lsb_value      = 1'b0;
               rsp_in.byte_ready     = emit_ready_ff;
               rsp_in.extracted_byte = emit_byte_ff;
               rsp_in.status         = emit_status_ff;
               rsp_in.last           = 1'b1;
            end
         end
         default: ;
      endcase

      // step one byte; a new row restarts the multiplier for its base
      if (do_advance) begin
         if (adv_wrap) begin
            col_in    = '0;
            row_in    = row_adv;
            mul_start = 1'b1;
            mul_a     = stored_row_adv;
            mul_b     = stride_ff;
         end else begin
            col_in = col_inc[COL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         mode_ff        <= MODE_RESTART;
         cnt_ff         <= '0;
         row_ff         <= '0;
         col_ff         <= '0;
         base_ff        <= '0;
         rbc_ff         <= '0;
         stride_ff      <= '0;
         bitpos_ff      <= '0;
         gather_ff      <= '0;
         done_bytes_ff  <= '0;
         capacity_ff    <= '0;
         emit_status_ff <= 1'b0;
         emit_ready_ff  <= 1'b0;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         mode_ff        <= mode_in;
         cnt_ff         <= cnt_in;
         row_ff         <= row_in;
         col_ff         <= col_in;
         base_ff        <= base_in;
         rbc_ff         <= rbc_in;
         stride_ff      <= stride_in;
         bitpos_ff      <= bitpos_in;
         gather_ff      <= gather_in;
         done_bytes_ff  <= done_bytes_in;
         capacity_ff    <= capacity_in;
         emit_status_ff <= emit_status_in;
         emit_ready_ff  <= emit_ready_in;
      end
      payload_ff   <= payload_in;
      emit_byte_ff <= emit_byte_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ bench/testbench.sv @@
// Self-checking bench for bmp_lsb_stego_embed_extract_core: directed script, then random phases.
// Depends on bmpsteg_pkg and the core RTL; predicts result words from its own model of the walk or a script row.
`timescale 1ns / 1ps

module testbench;
   import bmpsteg_pkg::*;

   localparam logic [1:0] MODE_UNUSED   = 2'd3;
   localparam int         SETTLE_CYCLES = 50;    // outlasts a restart or a row step
   localparam int         HOLD_CYCLES   = 400;   // long receiver hold-off
   localparam int         RANDOM_ITEMS  = 195;

   typedef enum logic {ROW_CSR, ROW_ITEM} row_kind_type;
   typedef enum logic [1:0] {SINK_OPEN, SINK_COIN, SINK_THIRD, SINK_SPARSE} sink_mode_type;

   // One line of the directed script: a register write or an item, with an
   // optional hand-written result for the single-word cases.
   typedef struct packed {
      row_kind_type          kind;
      logic [CSR_IDX_W-1:0]  reg_index;
      logic [CSR_DATA_W-1:0] reg_value;
      req_type               word;
      logic                  typed;
      rsp_type               result;
   } script_row_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   req_type                req_data;
   logic                   rsp_valid;
   logic                   rsp_ready;
   rsp_type                rsp_data;
   logic                   csr_write_enable;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   bmp_lsb_stego_embed_extract_core uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // ---------------------------------------------------------------------
   // Clock
   // ---------------------------------------------------------------------
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // ---------------------------------------------------------------------
   // Predictor state: register copies and the walk position
   // ---------------------------------------------------------------------
   logic [CFG_BPP_W-1:0] cfg_bpp;
   logic [CFG_DIM_W-1:0] cfg_width;
   logic [CFG_DIM_W-1:0] cfg_height;
   logic                 cfg_top_down;

   int unsigned          walk_row;
   int unsigned          walk_col;
   logic [ADDR_W-1:0]    walk_base;
   int unsigned          row_bytes;      // latched at restart
   int unsigned          stride;         // latched at restart
   logic [2:0]           gather_count;
   logic [7:0]           gather;
   int unsigned          bytes_used;
   int unsigned          capacity;       // whole bytes, latched at restart

   rsp_type              step_out [0:7];
   rsp_type              pending_pixel_ops [$];
   script_row_type       script [$];

   int unsigned          mismatch_count;
   int unsigned          burst_left;
   logic                 valid_high;
   logic                 hold_request;
   int unsigned          hold_left;
   int unsigned          sink_cycle;

   function automatic int unsigned dim_of(input logic [CFG_DIM_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_DIM_DEF) return MAX_DIM_DEF;
      return 32'(v);
   endfunction

   // Base of logical row 'row'; height and direction are read live, so a
   // write between passes shows up at the next row step.
   function automatic logic [ADDR_W-1:0] row_start_addr(input int unsigned row);
      int unsigned     h;
      int unsigned     r;
      int unsigned     stored_row;
      longint unsigned prod;
      h = dim_of(cfg_height);
      r = (row >= h) ? 0 : row;
      stored_row = cfg_top_down ? r : (h - 1 - r);
      prod = 64'(stored_row);
      prod = prod * stride;
      return prod[ADDR_W-1:0];
   endfunction

   function automatic logic [ADDR_W-1:0] walk_addr();
      return ADDR_W'(walk_base + walk_col);
   endfunction

   // Next visited byte; padding is never visited, last row wraps to the first.
   function automatic void step_walk();
      walk_col++;
      if (walk_col >= row_bytes) begin
         walk_col = 0;
         walk_row++;
         if (walk_row >= dim_of(cfg_height)) walk_row = 0;
         walk_base = row_start_addr(walk_row);
      end
   endfunction

   function automatic rsp_type plain_result(input logic [ADDR_W-1:0] addr, input logic st);
      rsp_type r;
      r = '0;
      r.pixel_address = addr;
      r.status = st;
      r.last = 1'b1;
      return r;
   endfunction

   // Works out the result words of one item into step_out; returns their count.
   function automatic int lsb_engine_step(input req_type w);
      int unsigned     px_w;
      int unsigned     px_h;
      int unsigned     bpp;
      longint unsigned cap;
      if ((w.mode == MODE_EMBED || w.mode == MODE_EXTRACT) && bytes_used >= capacity) begin
         // capacity used up: one flagged word, state untouched
         step_out[0] = plain_result(walk_addr(), 1'b1);
         return 1;
      end
      case (w.mode)
         MODE_RESTART: begin
            px_w = dim_of(cfg_width);
            px_h = dim_of(cfg_height);
            bpp = (cfg_bpp == BPP_32BIT) ? 4 : 3;
            row_bytes = px_w * bpp;
            stride = ((row_bytes + 3) / 4) * 4;
            cap = 64'(px_h);
            cap = (cap * row_bytes) / 8;
            capacity = cap[31:0];
            walk_row = 0;
            walk_col = 0;
            walk_base = row_start_addr(0);
            gather_count = '0;
            gather = '0;
            bytes_used = 0;
            step_out[0] = plain_result(walk_addr(), 1'b0);
            return 1;
         end
         MODE_EMBED: begin
            // a partly gathered byte is dropped
            gather_count = '0;
            gather = '0;
            for (int k = 0; k < 8; k++) begin
               step_out[k] = plain_result(walk_addr(), 1'b0);
               step_out[k].write_lsb = 1'b1;
               step_out[k].lsb_value = w.payload_byte[7 - k];
               step_out[k].last = (k == EMBED_LAST_BIT);
               step_walk();
            end
            bytes_used++;
            return 8;
         end
         MODE_EXTRACT: begin
            gather = {gather[6:0], w.pixel_byte[0]};
            gather_count = gather_count + 3'd1;
            step_walk();
            step_out[0] = plain_result(walk_addr(), 1'b0);
            if (gather_count == 0) begin
               step_out[0].byte_ready = 1'b1;
               step_out[0].extracted_byte = gather;
               gather = '0;
               bytes_used++;
            end
            return 1;
         end
         default: return 0;
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Directed script builders
   // ---------------------------------------------------------------------
   function automatic void add_reg(input logic [CSR_IDX_W-1:0] idx,
                                   input logic [CSR_DATA_W-1:0] value);
      script_row_type s;
      s = '0;
      s.kind = ROW_CSR;
      s.reg_index = idx;
      s.reg_value = value;
      script.push_back(s);
   endfunction

   function automatic void add_word(input logic [1:0] mode, input logic [7:0] payload,
                                    input logic [7:0] pixel);
      script_row_type s;
      s = '0;
      s.kind = ROW_ITEM;
      s.word.mode = mode;
      s.word.payload_byte = payload;
      s.word.pixel_byte = pixel;
      script.push_back(s);
   endfunction

   function automatic void add_checked(input logic [1:0] mode, input logic [7:0] payload,
                                       input logic [7:0] pixel, input logic [ADDR_W-1:0] addr,
                                       input logic st);
      script_row_type s;
      s = '0;
      s.kind = ROW_ITEM;
      s.word.mode = mode;
      s.word.payload_byte = payload;
      s.word.pixel_byte = pixel;
      s.typed = 1'b1;
      s.result = plain_result(addr, st);
      script.push_back(s);
   endfunction

   function automatic req_type random_word(input logic [1:0] mode);
      req_type w;
      w.mode = mode;
      w.payload_byte = 8'($urandom_range(0, 255));
      w.pixel_byte = 8'($urandom_range(0, 255));
      return w;
   endfunction

   // Mostly small dimensions so rows wrap and capacity runs out; a few huge.
   function automatic logic [CFG_DIM_W-1:0] pick_dim(input int unsigned small_max);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 85) return CFG_DIM_W'($urandom_range(1, small_max));
      if (r < 94) return CFG_DIM_W'($urandom_range(0, 32767));
      return '0;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_bpp();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 40) return CSR_DATA_W'(BPP_32BIT);
      if (r < 80) return CSR_DATA_W'(BPP_24BIT);
      return CSR_DATA_W'($urandom_range(0, 7));
   endfunction

   // ---------------------------------------------------------------------
   // Sender side; every drive happens at a falling edge
   // ---------------------------------------------------------------------
   task automatic drop_valid();
      if (valid_high) begin
         req_valid <= 1'b0;
         valid_high = 1'b0;
      end
   endtask

   // Bursts of random length separated by random gaps.
   task automatic pace_sender();
      int unsigned gap;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            drop_valid();
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
   endtask

   task automatic send_word(input req_type w, input logic typed, input rsp_type typed_rsp);
      int n;
      req_valid <= 1'b1;
      req_data <= w;
      valid_high = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      // word accepted at this edge: predict now
      n = lsb_engine_step(w);
      if (typed) pending_pixel_ops.push_back(typed_rsp);
      else for (int i = 0; i < n; i++) pending_pixel_ops.push_back(step_out[i]);
      @(negedge clock);
      pace_sender();
   endtask

   // Sender waits until every expected word is back, then lets the block
   // finish any trailing row step before registers are touched.
   task automatic wait_drained();
      drop_valid();
      while (pending_pixel_ops.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      case (idx)
         CSR_BYTES_PER_PIXEL: cfg_bpp = value[CFG_BPP_W-1:0];
         CSR_IMAGE_WIDTH:     cfg_width = value[CFG_DIM_W-1:0];
         CSR_IMAGE_HEIGHT:    cfg_height = value[CFG_DIM_W-1:0];
         default:             cfg_top_down = value[0];
      endcase
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Receiver: rotating stall pattern, plus one long hold-off on request
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      sink_cycle++;
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         case (sink_mode_type'((sink_cycle / 64) % 4))
            SINK_OPEN:  rsp_ready <= 1'b1;
            SINK_COIN:  rsp_ready <= 1'($urandom_range(0, 1));
            SINK_THIRD: rsp_ready <= (sink_cycle % 3 == 0);
            default:    rsp_ready <= ($urandom_range(0, 4) == 0);
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Checker: each accepted result word against the oldest expectation
   // ---------------------------------------------------------------------
   rsp_type want_word;

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         mismatch_count++;
         $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_pixel_ops.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected word, expected none actual %h", $time, rsp_data);
         end else begin
            want_word = pending_pixel_ops.pop_front();
            check_field("pixel_address", 32'(want_word.pixel_address),
                        32'(rsp_data.pixel_address));
            check_field("write_lsb", 32'(want_word.write_lsb), 32'(rsp_data.write_lsb));
            check_field("lsb_value", 32'(want_word.lsb_value), 32'(rsp_data.lsb_value));
            check_field("byte_ready", 32'(want_word.byte_ready), 32'(rsp_data.byte_ready));
            check_field("extracted_byte", 32'(want_word.extracted_byte),
                        32'(rsp_data.extracted_byte));
            check_field("status", 32'(want_word.status), 32'(rsp_data.status));
            check_field("last", 32'(want_word.last), 32'(rsp_data.last));
         end
      end
   end

   // Run limit
   initial begin
      #3_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin
      int unsigned random_items;
      int unsigned phase;
      int unsigned n_ops;
      int unsigned pick;
      req_type     w;

      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      hold_request = 1'b0;
      hold_left = 0;
      sink_cycle = 0;
      mismatch_count = 0;
      burst_left = 0;
      valid_high = 1'b0;

      // predictor matches the reset state of the block
      cfg_bpp = BPP_24BIT;
      cfg_width = 1;
      cfg_height = 1;
      cfg_top_down = 1'b0;
      walk_row = 0;
      walk_col = 0;
      walk_base = '0;
      row_bytes = 0;
      stride = 0;
      gather_count = '0;
      gather = '0;
      bytes_used = 0;
      capacity = 0;

      // Directed script. Before any restart capacity is zero: rejects.
      add_checked(MODE_EXTRACT, 8'h00, 8'hFF, 30'd0, 1'b1);
      add_checked(MODE_EMBED, 8'hFF, 8'h00, 30'd0, 1'b1);
      add_word(MODE_UNUSED, 8'hAA, 8'h55);                    // ignored, no word
      add_checked(MODE_RESTART, 8'h00, 8'h00, 30'd0, 1'b0);   // 1x1 24-bit
      add_checked(MODE_EMBED, 8'h00, 8'h00, 30'd0, 1'b1);     // 3 bytes hold no whole byte
      // 2x2 32-bit bottom-up: first row is file row 1 at 8, capacity 2
      add_reg(CSR_BYTES_PER_PIXEL, CSR_DATA_W'(BPP_32BIT));
      add_reg(CSR_IMAGE_WIDTH, 15'd2);
      add_reg(CSR_IMAGE_HEIGHT, 15'd2);
      add_reg(CSR_TOP_DOWN, 15'd0);
      add_checked(MODE_RESTART, 8'h00, 8'h00, 30'd8, 1'b0);
      add_word(MODE_EMBED, 8'hFF, 8'h00);
      add_word(MODE_EXTRACT, 8'h00, 8'hFF);
      add_word(MODE_EXTRACT, 8'h00, 8'h00);
      add_word(MODE_EMBED, 8'h5A, 8'h00);                     // drops the partial byte
      add_word(MODE_EXTRACT, 8'h00, 8'hFE);                   // capacity used up
      add_checked(MODE_RESTART, 8'hFF, 8'hFF, 30'd8, 1'b0);
      add_word(MODE_EXTRACT, 8'h00, 8'h01);
      add_word(MODE_EXTRACT, 8'h00, 8'h00);
      add_word(MODE_EXTRACT, 8'h00, 8'hFF);
      add_word(MODE_EXTRACT, 8'h00, 8'hFE);
      add_word(MODE_EXTRACT, 8'h00, 8'h81);
      add_word(MODE_EXTRACT, 8'h00, 8'h80);
      add_word(MODE_EXTRACT, 8'h00, 8'h7F);
      add_word(MODE_EXTRACT, 8'h00, 8'h03);                   // gathers 0xAB, steps to the next row
      // zero sizes read as 1, odd pixel code as 24-bit
      add_reg(CSR_BYTES_PER_PIXEL, 15'd0);
      add_reg(CSR_IMAGE_WIDTH, 15'd0);
      add_reg(CSR_IMAGE_HEIGHT, 15'd0);
      add_reg(CSR_TOP_DOWN, 15'd1);
      add_checked(MODE_RESTART, 8'h00, 8'h00, 30'd0, 1'b0);
      add_checked(MODE_EXTRACT, 8'h00, 8'hFF, 30'd0, 1'b1);
      // oversize clamps to 16384; bottom-up, last file row 16383 * 49152
      add_reg(CSR_BYTES_PER_PIXEL, 15'd7);
      add_reg(CSR_IMAGE_WIDTH, 15'h7FFF);
      add_reg(CSR_IMAGE_HEIGHT, 15'h7FFF);
      add_reg(CSR_TOP_DOWN, 15'd0);
      add_checked(MODE_RESTART, 8'h00, 8'h00, 30'd805257216, 1'b0);
      add_word(MODE_EMBED, 8'h80, 8'h00);
      // largest 32-bit image, top-down
      add_reg(CSR_BYTES_PER_PIXEL, CSR_DATA_W'(BPP_32BIT));
      add_reg(CSR_IMAGE_WIDTH, 15'd16384);
      add_reg(CSR_IMAGE_HEIGHT, 15'd16384);
      add_reg(CSR_TOP_DOWN, 15'd1);
      add_checked(MODE_RESTART, 8'h00, 8'h00, 30'd0, 1'b0);
      add_word(MODE_EMBED, 8'h01, 8'h00);

      // hold reset, then release it at a falling edge
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (script[i]) begin
         if (script[i].kind == ROW_CSR) begin
            wait_drained();
            csr_write(script[i].reg_index, script[i].reg_value);
         end else begin
            send_word(script[i].word, script[i].typed, script[i].result);
         end
      end

      // Random phases: new geometry and restart, or a mid-pass change of
      // height and direction; then embeds and whole extracted bytes with
      // some noise mixed in.
      random_items = 0;
      phase = 0;
      while (random_items < RANDOM_ITEMS) begin
         wait_drained();
         if (phase <= 1 || $urandom_range(0, 3) != 0) begin
            if (phase == 0 || $urandom_range(0, 3) != 0)
               csr_write(CSR_BYTES_PER_PIXEL, pick_bpp());
            if (phase == 0 || $urandom_range(0, 3) != 0)
               csr_write(CSR_IMAGE_WIDTH, pick_dim(12));
            if (phase == 0 || $urandom_range(0, 3) != 0)
               csr_write(CSR_IMAGE_HEIGHT, pick_dim(6));
            if (phase == 0 || $urandom_range(0, 3) != 0)
               csr_write(CSR_TOP_DOWN, CSR_DATA_W'($urandom_range(0, 1)));
            send_word(random_word(MODE_RESTART), 1'b0, '0);
            random_items++;
         end else begin
            if ($urandom_range(0, 1) != 0) csr_write(CSR_IMAGE_HEIGHT, pick_dim(6));
            if ($urandom_range(0, 1) != 0)
               csr_write(CSR_TOP_DOWN, CSR_DATA_W'($urandom_range(0, 1)));
         end
         // one long hold-off on the receiver while items keep coming
         if (phase == 1) hold_request = 1'b1;
         n_ops = $urandom_range(2, 8);
         repeat (n_ops) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
               send_word(random_word(MODE_EMBED), 1'b0, '0);
               random_items++;
            end else if (pick < 85) begin
               repeat (8) begin
                  send_word(random_word(MODE_EXTRACT), 1'b0, '0);
                  random_items++;
               end
            end else if (pick < 92) begin
               send_word(random_word(MODE_EXTRACT), 1'b0, '0);
               random_items++;
            end else if (pick < 96) begin
               send_word(random_word(MODE_UNUSED), 1'b0, '0);
            end else begin
               send_word(random_word(MODE_RESTART), 1'b0, '0);
               random_items++;
            end
         end
         phase++;
      end

      wait_drained();
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/bmpsteg_pkg.sv
rtl/bmpsteg_serial_mul.sv
rtl/bmp_lsb_stego_embed_extract_core.sv
bench/testbench.sv
